FILE: rtl/dcve_pkg.sv
`timescale 1ns / 1ps

package dcve_pkg;

  localparam int DEF_VALUE_WIDTH = 27;
  localparam int DEF_MAX_PLACES  = 8;
  localparam int WEIGHT_WIDTH    = 24;
  localparam int DIGIT_SLOTS     = 8;
  localparam int BCD_WIDTH       = 4 * DIGIT_SLOTS;
  localparam int STEP_WIDTH      = 3;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [31:0] MAX_LIMIT_RESET   = 32'd99999999;
  localparam logic [3:0]  DIGIT_COUNT_RESET = 4'd8;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_INC   = 3'd1;
  localparam logic [2:0] MODE_DEC   = 3'd2;
  localparam logic [2:0] MODE_RIGHT = 3'd3;
  localparam logic [2:0] MODE_LEFT  = 3'd4;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_LIMIT   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIGIT_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ACT_NOP     = 3'd0,
    ACT_CAPTURE = 3'd1,
    ACT_APPLY   = 3'd2,
    ACT_SHIFT   = 3'd3,
    ACT_SEARCH  = 3'd4,
    ACT_EMIT    = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    COND_NEXT       = 3'd0,
    COND_ALWAYS     = 3'd1,
    COND_IN_IDLE    = 3'd2,
    COND_SHIFT_MORE = 3'd3,
    COND_OUT_BUSY   = 3'd4
  } cond_t;

  typedef struct packed {
    act_t                  act;
    cond_t                 cond;
    logic [STEP_WIDTH-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic shift_last;
    logic out_busy;
  } dp_status_t;

  function automatic ctrl_word_t program_rom(input logic [STEP_WIDTH-1:0] step);
    ctrl_word_t w;
    unique case (step)
      3'd0:    w = '{act: ACT_CAPTURE, cond: COND_IN_IDLE,    target: 3'd0};
      3'd1:    w = '{act: ACT_APPLY,   cond: COND_NEXT,       target: 3'd0};
      3'd2:    w = '{act: ACT_SHIFT,   cond: COND_SHIFT_MORE, target: 3'd2};
      3'd3:    w = '{act: ACT_SEARCH,  cond: COND_NEXT,       target: 3'd0};
      3'd4:    w = '{act: ACT_NOP,     cond: COND_OUT_BUSY,   target: 3'd4};
      3'd5:    w = '{act: ACT_EMIT,    cond: COND_ALWAYS,     target: 3'd0};
      default: w = '{act: ACT_NOP,     cond: COND_ALWAYS,     target: 3'd0};
    endcase
    return w;
  endfunction

  function automatic logic [WEIGHT_WIDTH-1:0] pow10(input logic [2:0] k);
    logic [WEIGHT_WIDTH-1:0] p;
    case (k)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/digit_cursor_value_editor.sv
`timescale 1ns / 1ps

// Decimal value editor for a front panel: holds a value and a digit cursor,
// loads, steps by the weight of the cursor place with clamping to the limits,
// moves the cursor with wrap, and reports the digit at a queried place. Each
// transaction runs a six-step microprogram: capture, apply, eight digit steps
// that each divide by ten through a reciprocal multiplication, the digit
// search, an output wait step and the emit step. A result still held in the
// output register keeps the next item in the wait step while it is held. One
// item is processed at a time; a finished result sits in the output register
// while the next item is taken. Limits and digit count are written through
// the configuration port; the user must write them only while the block is
// idle (not enforced); a write to an unused index is ignored.
module digit_cursor_value_editor #(
  parameter int VALUE_WIDTH = dcve_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_PLACES  = dcve_pkg::DEF_MAX_PLACES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dcve_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]                cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            mode,
  input  logic [VALUE_WIDTH-1:0]                new_value,
  input  logic [2:0]                            query_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [VALUE_WIDTH-1:0]                edit_value,
  output logic [2:0]                            cursor_place,
  output logic [3:0]                            queried_digit
);

  dcve_pkg::ctrl_word_t ctrl;
  dcve_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;
  assign in_ready  = (ctrl.act == dcve_pkg::ACT_CAPTURE);

  dcve_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  dcve_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_PLACES  (MAX_PLACES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .mode           (mode),
    .new_value      (new_value),
    .query_position (query_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edit_value     (edit_value),
    .cursor_place   (cursor_place),
    .queried_digit  (queried_digit)
  );

endmodule

FILE: rtl/dcve_seq.sv
`timescale 1ns / 1ps

module dcve_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  dcve_pkg::dp_status_t    status,
  output dcve_pkg::ctrl_word_t    ctrl
);

  logic [dcve_pkg::STEP_WIDTH-1:0] step;
  logic [dcve_pkg::STEP_WIDTH-1:0] step_next;
  logic                            take;

  assign ctrl = dcve_pkg::program_rom(step);

  always_comb begin
    unique case (ctrl.cond)
      dcve_pkg::COND_NEXT:       take = 1'b0;
      dcve_pkg::COND_ALWAYS:     take = 1'b1;
      dcve_pkg::COND_IN_IDLE:    take = !in_valid;
      dcve_pkg::COND_SHIFT_MORE: take = !status.shift_last;
      dcve_pkg::COND_OUT_BUSY:   take = status.out_busy;
      default:                   take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: rtl/dcve_dp.sv
`timescale 1ns / 1ps

module dcve_dp #(
  parameter int VALUE_WIDTH = dcve_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_PLACES  = dcve_pkg::DEF_MAX_PLACES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dcve_pkg::ctrl_word_t                  ctrl,
  output dcve_pkg::dp_status_t                  status,
  input  logic                                  cfg_valid,
  input  logic [dcve_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]                cfg_data,
  input  logic                                  in_valid,
  input  logic [2:0]                            mode,
  input  logic [VALUE_WIDTH-1:0]                new_value,
  input  logic [2:0]                            query_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [VALUE_WIDTH-1:0]                edit_value,
  output logic [2:0]                            cursor_place,
  output logic [3:0]                            queried_digit
);

  localparam int AW = ((VALUE_WIDTH > dcve_pkg::WEIGHT_WIDTH) ?
                       VALUE_WIDTH : dcve_pkg::WEIGHT_WIDTH) + 1;
  localparam int CW = $clog2(dcve_pkg::DIGIT_SLOTS + 1);
  localparam logic [3:0]  PLACES_CAP = 4'(MAX_PLACES);
  localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;

  logic [VALUE_WIDTH-1:0]         min_limit;
  logic [VALUE_WIDTH-1:0]         max_limit;
  logic [3:0]                     digit_count;
  logic [VALUE_WIDTH-1:0]         value;
  logic [VALUE_WIDTH-1:0]         value_next;
  logic [2:0]                     cursor;
  logic [2:0]                     cursor_next;
  logic [2:0]                     op_mode;
  logic [VALUE_WIDTH-1:0]         op_value;
  logic [2:0]                     op_query;
  logic [VALUE_WIDTH-1:0]         dividend;
  logic [dcve_pkg::BCD_WIDTH-1:0] bcd;
  logic [CW-1:0]                  digit_cnt;

  logic [31:0]                    div_in;
  logic [63:0]                    div_prod;
  logic [28:0]                    div_q;
  logic [31:0]                    div_q10;
  logic [31:0]                    div_rem;

  logic [3:0]                     places;
  logic [dcve_pkg::WEIGHT_WIDTH-1:0] weight;
  logic [AW-1:0]                  value_w;
  logic [AW-1:0]                  weight_w;
  logic [AW-1:0]                  sum;
  logic [AW-1:0]                  diff;
  logic [2:0]                     found;
  logic [3:0]                     qdigit;

  function automatic logic [VALUE_WIDTH-1:0] clamp(
    input logic [AW-1:0]          v,
    input logic [VALUE_WIDTH-1:0] lo,
    input logic [VALUE_WIDTH-1:0] hi
  );
    logic [VALUE_WIDTH-1:0] r;
    if (v < AW'(lo)) r = lo;
    else if (v > AW'(hi)) r = hi;
    else r = v[VALUE_WIDTH-1:0];
    return r;
  endfunction

  always_comb begin
    if (digit_count == 4'd0) places = 4'd1;
    else if (digit_count > PLACES_CAP) places = PLACES_CAP;
    else places = digit_count;
  end

  always_comb begin
    logic [3:0] k;
    k = places - {1'b0, cursor} - 4'd1;
    if ({1'b0, cursor} + 4'd1 >= places) weight = dcve_pkg::WEIGHT_WIDTH'(1);
    else weight = dcve_pkg::pow10(k[2:0]);
  end

  assign value_w  = AW'(value);
  assign weight_w = AW'(weight);
  assign sum      = value_w + weight_w;
  assign diff     = value_w - weight_w;

  always_comb begin
    value_next  = value;
    cursor_next = cursor;
    case (op_mode)
      dcve_pkg::MODE_LOAD: begin
        value_next  = clamp(AW'(op_value), min_limit, max_limit);
        cursor_next = 3'd0;
      end
      dcve_pkg::MODE_INC: begin
        if (value < max_limit) value_next = clamp(sum, min_limit, max_limit);
      end
      dcve_pkg::MODE_DEC: begin
        if (value > min_limit) begin
          if (weight_w > value_w) value_next = min_limit;
          else value_next = clamp(diff, min_limit, max_limit);
        end
      end
      dcve_pkg::MODE_RIGHT: begin
        if ({1'b0, cursor} + 4'd1 < places) cursor_next = cursor + 3'd1;
        else cursor_next = 3'd0;
      end
      dcve_pkg::MODE_LEFT: begin
        if (cursor != 3'd0) cursor_next = cursor - 3'd1;
        else cursor_next = 3'(places - 4'd1);
      end
      default: ;
    endcase
  end

  // divide by ten through the reciprocal, one decimal digit a step
  assign div_in   = 32'(dividend);
  assign div_prod = 64'(div_in) * 64'(RECIP_TEN);
  assign div_q    = div_prod[63:35];
  assign div_q10  = {div_q, 3'b000} + {2'b00, div_q, 1'b0};
  assign div_rem  = div_in - div_q10;

  always_comb begin
    logic [3:0] idx;
    found = 3'd0;
    for (int i = dcve_pkg::DIGIT_SLOTS - 1; i >= 0; i--) begin
      idx = places - 4'(i) - 4'd1;
      if (4'(i) < places && bcd[4*idx[2:0] +: 4] != 4'd0) found = 3'(i);
    end
  end

  always_comb begin
    logic [3:0] idx;
    idx = places - {1'b0, op_query} - 4'd1;
    if ({1'b0, op_query} < places) qdigit = bcd[4*idx[2:0] +: 4];
    else qdigit = 4'd0;
  end

  assign status = '{shift_last: (digit_cnt == CW'(1)),
                    out_busy:   (out_valid && !out_ready)};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_limit   <= '0;
      max_limit   <= dcve_pkg::MAX_LIMIT_RESET[VALUE_WIDTH-1:0];
      digit_count <= dcve_pkg::DIGIT_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dcve_pkg::REG_MIN_LIMIT:   min_limit   <= cfg_data;
        dcve_pkg::REG_MAX_LIMIT:   max_limit   <= cfg_data;
        dcve_pkg::REG_DIGIT_COUNT: digit_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.act == dcve_pkg::ACT_APPLY) begin
        value  <= value_next;
        cursor <= cursor_next;
      end
      if (ctrl.act == dcve_pkg::ACT_SEARCH && op_mode == dcve_pkg::MODE_LOAD) begin
        cursor <= found;
      end
      if (ctrl.act == dcve_pkg::ACT_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == dcve_pkg::ACT_CAPTURE && in_valid) begin
      op_mode  <= mode;
      op_value <= new_value;
      op_query <= query_position;
    end
    if (ctrl.act == dcve_pkg::ACT_APPLY) begin
      dividend  <= value_next;
      bcd       <= '0;
      digit_cnt <= CW'(dcve_pkg::DIGIT_SLOTS);
    end
    if (ctrl.act == dcve_pkg::ACT_SHIFT) begin
      bcd       <= {div_rem[3:0], bcd[dcve_pkg::BCD_WIDTH-1:4]};
      dividend  <= VALUE_WIDTH'(div_q);
      digit_cnt <= digit_cnt - CW'(1);
    end
    if (ctrl.act == dcve_pkg::ACT_EMIT) begin
      edit_value    <= value;
      cursor_place  <= cursor;
      queried_digit <= qdigit;
    end
  end

endmodule

FILE: rtl/dcve_chk.sv
`timescale 1ns / 1ps

module dcve_chk #(
  parameter int VALUE_WIDTH = dcve_pkg::DEF_VALUE_WIDTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] edit_value,
  input logic [3:0]             queried_digit
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edit_value))
    else $error("stalled result changed");

  // drop ready while a transaction is in work
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during processing");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("more than one result for a transaction");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> queried_digit <= 4'd9)
    else $error("queried digit is not decimal");

endmodule

bind digit_cursor_value_editor dcve_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .edit_value    (edit_value),
  .queried_digit (queried_digit)
);

FILE: test/digit_cursor_value_editor_tb.sv
`timescale 1ns / 1ps

module digit_cursor_value_editor_tb;
  import dcve_pkg::*;

  localparam int VW        = DEF_VALUE_WIDTH;
  localparam int MAX_SHOWN = DEF_MAX_PLACES;

  localparam logic [VW-1:0] VALUE_ALL_ONES = '1;

  localparam logic [2:0] MODE_QUERY    = 3'd5;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 73;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 64;

  localparam bit TYPED = 1'b1;
  localparam bit PRED  = 1'b0;

  typedef struct packed {
    logic [VW-1:0] value;
    logic [2:0]    cursor;
    logic [3:0]    digit;
  } edit_result_t;

  typedef struct packed {
    logic [2:0]    mode;
    logic [VW-1:0] value;
    logic [2:0]    place;
    bit            typed;
    edit_result_t  want;
  } panel_row_t;

  localparam edit_result_t NO_RESULT = '0;

  localparam int DIRECTED_ROWS = 23;
  localparam panel_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{MODE_QUERY,    VALUE_ALL_ONES,  3'd0, TYPED, '{27'd0,        3'd0, 4'd0}},
    '{MODE_LOAD,     27'd99999999,    3'd7, TYPED, '{27'd99999999, 3'd0, 4'd9}},
    '{MODE_INC,      27'd0,           3'd3, TYPED, '{27'd99999999, 3'd0, 4'd9}},
    '{MODE_LOAD,     VALUE_ALL_ONES,  3'd0, TYPED, '{27'd99999999, 3'd0, 4'd9}},
    '{MODE_LOAD,     27'd0,           3'd5, TYPED, '{27'd0,        3'd0, 4'd0}},
    '{MODE_DEC,      27'd0,           3'd0, TYPED, '{27'd0,        3'd0, 4'd0}},
    '{MODE_LEFT,     27'd0,           3'd0, TYPED, '{27'd0,        3'd7, 4'd0}},
    '{MODE_RIGHT,    27'd0,           3'd0, TYPED, '{27'd0,        3'd0, 4'd0}},
    '{MODE_INC,      27'd0,           3'd0, PRED,  NO_RESULT},
    '{MODE_LOAD,     27'd5,           3'd7, TYPED, '{27'd5,        3'd7, 4'd5}},
    '{MODE_INC,      27'd0,           3'd7, PRED,  NO_RESULT},
    '{MODE_LEFT,     27'd0,           3'd6, PRED,  NO_RESULT},
    '{MODE_DEC,      27'd0,           3'd7, PRED,  NO_RESULT},
    '{MODE_LOAD,     27'd12345678,    3'd0, PRED,  NO_RESULT},
    '{MODE_RIGHT,    27'd0,           3'd1, PRED,  NO_RESULT},
    '{MODE_RIGHT,    27'd0,           3'd2, PRED,  NO_RESULT},
    '{MODE_DEC,      27'd0,           3'd2, PRED,  NO_RESULT},
    '{MODE_INC,      27'd0,           3'd2, PRED,  NO_RESULT},
    '{MODE_SPARE_LO, 27'd31415926,    3'd4, PRED,  NO_RESULT},
    '{MODE_SPARE_HI, 27'd0,           3'd6, PRED,  NO_RESULT},
    '{MODE_LOAD,     27'd99999990,    3'd7, PRED,  NO_RESULT},
    '{MODE_INC,      27'd0,           3'd0, PRED,  NO_RESULT},
    '{MODE_LOAD,     27'd400,         3'd5, PRED,  NO_RESULT}
  };

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [VW-1:0]              cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [2:0]                 mode;
  logic [VW-1:0]              new_value;
  logic [2:0]                 query_position;
  logic                       out_valid;
  logic                       out_ready;
  logic [VW-1:0]              edit_value;
  logic [2:0]                 cursor_place;
  logic [3:0]                 queried_digit;

  logic [VW-1:0] panel_min;
  logic [VW-1:0] panel_max;
  logic [3:0]    panel_count;
  logic [VW-1:0] panel_value;
  logic [2:0]    panel_cursor;

  edit_result_t pending_results[$];
  int           mismatches;
  int           quiet_cycles;
  bit           sender_gaps;
  bit           sink_gaps;
  bit           hold_request;

  digit_cursor_value_editor DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .new_value      (new_value),
    .query_position (query_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edit_value     (edit_value),
    .cursor_place   (cursor_place),
    .queried_digit  (queried_digit)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned ten_pow(input longint unsigned k);
    longint unsigned p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function automatic longint unsigned clamp_to_limits(input longint unsigned v);
    if (v < panel_min) return panel_min;
    if (v > panel_max) return panel_max;
    return v;
  endfunction

  function automatic logic [3:0] digit_of(input longint unsigned v,
                                          input longint unsigned place,
                                          input longint unsigned n);
    if (place >= n) return 4'd0;
    return 4'((v / ten_pow(n - place - 1)) % 10);
  endfunction

  function automatic edit_result_t edit_panel(input logic [2:0] m, input logic [VW-1:0] nv,
                                              input logic [2:0] qp);
    edit_result_t    r;
    longint unsigned n;
    longint unsigned step;
    longint unsigned cur;
    int              i;
    n = (panel_count == 0) ? 1 : ((panel_count > MAX_SHOWN) ? MAX_SHOWN : panel_count);
    cur = panel_cursor;
    step = (cur + 1 >= n) ? 1 : ten_pow(n - cur - 1);
    case (m)
      MODE_LOAD: begin
        panel_value = VW'(clamp_to_limits(nv));
        panel_cursor = 3'd0;
        for (i = 0; i < n; i++) begin
          if (digit_of(panel_value, i, n) != 0) begin
            panel_cursor = 3'(i);
            break;
          end
        end
      end
      MODE_INC: begin
        if (panel_value < panel_max)
          panel_value = VW'(clamp_to_limits(longint'(panel_value) + step));
      end
      MODE_DEC: begin
        if (panel_value > panel_min) begin
          if (step > panel_value) panel_value = panel_min;
          else panel_value = VW'(clamp_to_limits(longint'(panel_value) - step));
        end
      end
      MODE_RIGHT: panel_cursor = (cur + 1 < n) ? 3'(cur + 1) : 3'd0;
      MODE_LEFT:  panel_cursor = (cur > 0) ? 3'(cur - 1) : 3'(n - 1);
      default: ;
    endcase
    r.value  = panel_value;
    r.cursor = panel_cursor;
    r.digit  = digit_of(panel_value, qp, n);
    return r;
  endfunction

  function automatic logic [VW-1:0] pick_value();
    longint t;
    case ($urandom_range(0, 6))
      0: t = $urandom_range(0, VALUE_ALL_ONES);
      1: t = $urandom_range(0, 99999999);
      2: t = longint'(panel_min) + longint'($urandom_range(0, 20)) - 10;
      3: t = longint'(panel_max) + longint'($urandom_range(0, 20)) - 10;
      4: t = longint'($urandom_range(1, 9) * ten_pow($urandom_range(0, 7)));
      5: t = $urandom_range(0, 999);
      default: t = longint'($urandom) & longint'(VALUE_ALL_ONES);
    endcase
    if (t < 0) t = 0;
    if (t > longint'(VALUE_ALL_ONES)) t = VALUE_ALL_ONES;
    return VW'(t);
  endfunction

  task automatic post_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                               input logic [VW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_MIN_LIMIT:   panel_min = data;
      REG_MAX_LIMIT:   panel_max = data;
      REG_DIGIT_COUNT: panel_count = data[3:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(input logic [VW-1:0] lo, input logic [VW-1:0] hi,
                                input logic [3:0] count);
    logic [VW-1:0] count_word;
    count_word = VW'($urandom);
    if ($urandom_range(0, 1)) count_word = '0;
    count_word[3:0] = count;
    if ($urandom_range(0, 1)) post_register(REG_UNUSED, VW'($urandom));
    post_register(REG_MIN_LIMIT, lo);
    post_register(REG_MAX_LIMIT, hi);
    post_register(REG_DIGIT_COUNT, count_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [2:0] m, input logic [VW-1:0] nv,
                           input logic [2:0] qp, input bit typed,
                           input edit_result_t typed_want);
    edit_result_t r;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    new_value      <= nv;
    query_position <= qp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = edit_panel(m, nv, qp);
    pending_results.push_back(typed ? typed_want : r);
  endtask

  task automatic send_random_item();
    int         pick;
    logic [2:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 14)      m = MODE_LOAD;
    else if (pick < 38) m = MODE_INC;
    else if (pick < 62) m = MODE_DEC;
    else if (pick < 75) m = MODE_RIGHT;
    else if (pick < 88) m = MODE_LEFT;
    else if (pick < 95) m = MODE_QUERY;
    else                m = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
    send_item(m, pick_value(), 3'($urandom_range(0, 7)), PRED, NO_RESULT);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic log_mismatch(input string what, input edit_result_t want,
                              input edit_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected value %0d cursor %0d digit %0d,",
               $realtime, what, want.value, want.cursor, want.digit,
               " got value %0d cursor %0d digit %0d",
               got.value, got.cursor, got.digit);
  endtask

  always @(posedge clk) begin : check_results
    edit_result_t got;
    edit_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{edit_value, cursor_place, queried_digit};
      if (pending_results.size() == 0) begin
        log_mismatch("result with nothing pending", NO_RESULT, got);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.cursor !== want.cursor ||
            got.digit !== want.digit)
          log_mismatch("wrong result", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("digit_cursor_value_editor_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int            i;
    int            ph;
    int            k;
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
    logic [3:0]    cnt;
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_MIN_LIMIT;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    mode           <= MODE_QUERY;
    new_value      <= '0;
    query_position <= 3'd0;
    mismatches   = 0;
    quiet_cycles = 0;
    sender_gaps  = 1'b1;
    sink_gaps    = 1'b1;
    hold_request = 1'b0;
    panel_min    = '0;
    panel_max    = VW'(MAX_LIMIT_RESET);
    panel_count  = DIGIT_COUNT_RESET;
    panel_value  = '0;
    panel_cursor = 3'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++)
      send_item(DIRECTED[i].mode, DIRECTED[i].value, DIRECTED[i].place,
                DIRECTED[i].typed, DIRECTED[i].want);

    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin lo = '0; hi = VALUE_ALL_ONES; cnt = 4'd8; end
        1: begin lo = '0; hi = 27'd99999999; cnt = 4'd0; end
        2: begin lo = 27'd1000; hi = 27'd5000; cnt = 4'd4; end
        3: begin
          lo = VW'($urandom_range(0, 99999999));
          hi = lo;
          cnt = 4'($urandom_range(1, 8));
        end
        4: begin lo = 27'd60000; hi = 27'd20000; cnt = 4'd6; end
        5: begin lo = VALUE_ALL_ONES; hi = VALUE_ALL_ONES; cnt = 4'd15; end
        8: begin lo = '0; hi = 27'd999; cnt = 4'd3; end
        9: begin lo = '0; hi = VW'(MAX_LIMIT_RESET); cnt = DIGIT_COUNT_RESET; end
        default: begin
          lo = VW'($urandom_range(0, 50000000));
          hi = lo + VW'($urandom_range(0, 60000000));
          cnt = 4'($urandom_range(0, 15));
        end
      endcase
      program_limits(lo, hi, cnt);
      sender_gaps = (ph < PHASES - 2) && (ph != 2);
      sink_gaps   = (ph < PHASES - 2) && (ph != 6);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 10) hold_request = 1'b1;
        if (ph == 4 && k == 30) drain_results();
        send_random_item();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("digit_cursor_value_editor_tb: PASS");
    end else begin
      $display("digit_cursor_value_editor_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dcve_pkg.sv
rtl/dcve_seq.sv
rtl/dcve_dp.sv
rtl/digit_cursor_value_editor.sv
rtl/dcve_chk.sv
test/digit_cursor_value_editor_tb.sv
